>>> rtl/mpfd_pkg.sv
// ----------------------------------------------------------------------------
// mpfd_pkg
// Shared types, constants and helpers of the multi-package frame deframer.
// ----------------------------------------------------------------------------
package mpfd_pkg;

    localparam int          LEN_WIDTH_DEF  = 32;
    localparam logic [3:0]  HEADER_BYTES   = 4'd10;
    localparam logic [3:0]  MAGIC_BYTES    = 4'd6;
    localparam logic [3:0]  MODE_MAX       = 4'h3;
    localparam logic [7:0]  METHOD_MAX     = 8'h09;
    localparam logic [7:0]  CTRL_LEN_MASK  = 8'h03;
    localparam logic [7:0]  CTRL_MORE_MASK = 8'h0C;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_CONTROL = 2'd1,
        PH_SIZE    = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_CONTINUE  = 2'd0,
        ST_HEADER_OK = 2'd1,
        ST_OVER      = 2'd2,
        ST_ILLEGAL   = 2'd3
    } t_status;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       frame_last;
        logic       package_last;
        logic       request_last;
        t_status    status;
        logic       header_valid;
        logic [7:0] version_byte;
        logic [3:0] compress_mode;
        logic [3:0] encrypt_mode;
        logic [7:0] method_code;
        logic [7:0] package_count;
    } t_result;

    // Expected header magic, one byte per position.
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h23;
            3'd1:    val = 8'h4D;
            3'd2:    val = 8'h46;
            3'd3:    val = 8'h50;
            3'd4:    val = 8'h54;
            3'd5:    val = 8'h50;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/mpfd_if.sv
// ----------------------------------------------------------------------------
// mpfd_in_if / mpfd_out_if
// Valid/ready channels carrying received bytes in and deframed results out.
// ----------------------------------------------------------------------------
interface mpfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface mpfd_out_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_last;
    logic       package_last;
    logic       request_last;
    logic [1:0] status;
    logic       header_valid;
    logic [7:0] version_byte;
    logic [3:0] compress_mode;
    logic [3:0] encrypt_mode;
    logic [7:0] method_code;
    logic [7:0] package_count;

    modport source (
        output valid, output payload_valid, output payload_byte, output frame_last,
        output package_last, output request_last, output status, output header_valid,
        output version_byte, output compress_mode, output encrypt_mode,
        output method_code, output package_count, input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input frame_last,
        input package_last, input request_last, input status, input header_valid,
        input version_byte, input compress_mode, input encrypt_mode,
        input method_code, input package_count, output ready
    );
endinterface

>>> rtl/multi_package_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// multi_package_frame_deframer_top
// Byte-stream deframer: header check, frame sizing and payload pass-through.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock and gives one result beat per
// byte, also one beat per clock, while the output is not stalled. A byte is
// caught in an input register, goes through the combinational parsing logic
// and lands in the result register, from which its result is offered on the
// output; while the output stalls, the byte waits in the input register.
// The heartbeat method register must only be written while no byte is in flight.
module multi_package_frame_deframer_top #(
    parameter int LENGTH_WIDTH = mpfd_pkg::LEN_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpfd_in_if.sink    i_in,
    mpfd_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata
);
    import mpfd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic [3:0] r_heartbeat;
    logic       out_free;
    logic       step;
    t_result    result;

    assign step       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_heartbeat <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (i_cfg_we) begin
                r_heartbeat <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
        end
    end

    mpfd_deframe #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_deframe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_heartbeat (r_heartbeat),
        .o_result    (result)
    );

    mpfd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

    // A completed request always closes both its frame and its package.
    a_request_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.request_last |-> o_out.frame_last && o_out.package_last)
        else $error("request end without frame and package end");

    // Header verdicts come only with the reported header fields.
    a_header_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == ST_HEADER_OK |-> o_out.header_valid
            && !o_out.payload_valid)
        else $error("header accepted without header fields");

    // A byte sitting in the input register is not lost when the output stalls.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_in_byte))
        else $error("input register dropped a byte under backpressure");

endmodule

>>> rtl/mpfd_deframe.sv
// ----------------------------------------------------------------------------
// mpfd_deframe
// Parser state and the combinational step that turns one byte into a result.
// ----------------------------------------------------------------------------
module mpfd_deframe #(
    parameter int LENGTH_WIDTH = mpfd_pkg::LEN_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic [3:0]        i_heartbeat,
    output mpfd_pkg::t_result o_result
);
    import mpfd_pkg::*;

    t_phase                  r_phase,      n_phase;
    logic [3:0]              r_hdr_cnt,    n_hdr_cnt;
    logic                    r_mismatch,   n_mismatch;
    logic [31:0]             r_fields,     n_fields;
    logic [7:0]              r_pkg_done,   n_pkg_done;
    logic [2:0]              r_size_left,  n_size_left;
    logic                    r_more,       n_more;
    logic [LENGTH_WIDTH-1:0] r_frm_size,   n_frm_size;
    logic [LENGTH_WIDTH-1:0] r_pay_left,   n_pay_left;

    logic [LENGTH_WIDTH+7:0] len_shift;
    logic [31:0]             hdr_next;
    logic [7:0]              pkg_inc;
    logic                    frame_end;
    logic [3:0]              comp;
    logic [3:0]              enc;
    logic [7:0]              meth;
    logic [7:0]              cnt;

    // The header fields as they stand once the current byte is shifted in.
    assign hdr_next  = {r_fields[23:0], i_byte};
    assign len_shift = {r_frm_size, i_byte};
    assign pkg_inc   = r_pkg_done + 8'd1;
    assign comp      = hdr_next[23:20];
    assign enc       = hdr_next[19:16];
    assign meth      = hdr_next[15:8];
    assign cnt       = hdr_next[7:0];

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_mismatch  = r_mismatch;
        n_fields    = r_fields;
        n_pkg_done  = r_pkg_done;
        n_size_left = r_size_left;
        n_more      = r_more;
        n_frm_size  = r_frm_size;
        n_pay_left  = r_pay_left;
        frame_end   = 1'b0;
        o_result    = '0;

        case (r_phase)
            PH_HEADER: begin
                if (r_hdr_cnt < MAGIC_BYTES) begin
                    if (i_byte != magic_byte(r_hdr_cnt[2:0])) begin
                        n_mismatch = 1'b1;
                    end
                end else begin
                    n_fields = hdr_next;
                end
                n_hdr_cnt = r_hdr_cnt + 4'd1;
                if (n_hdr_cnt >= HEADER_BYTES) begin
                    o_result.header_valid  = 1'b1;
                    o_result.version_byte  = hdr_next[31:24];
                    o_result.compress_mode = comp;
                    o_result.encrypt_mode  = enc;
                    o_result.method_code   = meth;
                    o_result.package_count = cnt;
                    n_phase    = PH_HEADER;
                    n_hdr_cnt  = '0;
                    n_mismatch = 1'b0;
                    if (r_mismatch || comp > MODE_MAX || enc > MODE_MAX
                            || meth > METHOD_MAX) begin
                        o_result.status = ST_ILLEGAL;
                    end else if (meth == {4'd0, i_heartbeat}) begin
                        o_result.status = ST_OVER;
                    end else if (cnt == 8'd0) begin
                        o_result.status = ST_ILLEGAL;
                    end else begin
                        o_result.status = ST_HEADER_OK;
                        n_pkg_done      = '0;
                        n_phase         = PH_CONTROL;
                    end
                end
            end
            PH_CONTROL: begin
                n_size_left = {1'b0, i_byte[1:0] & CTRL_LEN_MASK[1:0]} + 3'd1;
                n_more      = (i_byte & CTRL_MORE_MASK) != 8'd0;
                n_frm_size  = '0;
                n_phase     = PH_SIZE;
            end
            PH_SIZE: begin
                n_frm_size = len_shift[LENGTH_WIDTH-1:0];
                if (r_size_left <= 3'd1) begin
                    n_size_left = '0;
                    n_pay_left  = n_frm_size;
                    if (n_frm_size == '0) begin
                        frame_end = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_size_left = r_size_left - 3'd1;
                end
            end
            PH_PAYLOAD: begin
                o_result.payload_valid = 1'b1;
                o_result.payload_byte  = i_byte;
                if (r_pay_left <= LENGTH_WIDTH'(1)) begin
                    n_pay_left = '0;
                    frame_end  = 1'b1;
                end else begin
                    n_pay_left = r_pay_left - LENGTH_WIDTH'(1);
                end
            end
            default: begin
                n_phase    = PH_HEADER;
                n_hdr_cnt  = '0;
                n_mismatch = 1'b0;
            end
        endcase

        // Frame completion decides whether the package and the request end.
        if (frame_end) begin
            o_result.frame_last = 1'b1;
            n_phase             = PH_CONTROL;
            if (!r_more) begin
                o_result.package_last = 1'b1;
                n_pkg_done            = pkg_inc;
                if (pkg_inc == r_fields[7:0]) begin
                    o_result.request_last = 1'b1;
                    o_result.status       = ST_OVER;
                    n_phase               = PH_HEADER;
                    n_hdr_cnt             = '0;
                    n_mismatch            = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= '0;
            r_mismatch  <= 1'b0;
            r_fields    <= '0;
            r_pkg_done  <= '0;
            r_size_left <= '0;
            r_more      <= 1'b0;
            r_frm_size  <= '0;
            r_pay_left  <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_mismatch  <= n_mismatch;
            r_fields    <= n_fields;
            r_pkg_done  <= n_pkg_done;
            r_size_left <= n_size_left;
            r_more      <= n_more;
            r_frm_size  <= n_frm_size;
            r_pay_left  <= n_pay_left;
        end
    end

endmodule

>>> rtl/mpfd_out_reg.sv
// ----------------------------------------------------------------------------
// mpfd_out_reg
// Result register that drives the output channel and frees when taken.
// ----------------------------------------------------------------------------
module mpfd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mpfd_pkg::t_result i_result,
    output logic              o_free,
    mpfd_out_if.source        o_out
);
    import mpfd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.payload_valid = r_result.payload_valid;
    assign o_out.payload_byte  = r_result.payload_byte;
    assign o_out.frame_last    = r_result.frame_last;
    assign o_out.package_last  = r_result.package_last;
    assign o_out.request_last  = r_result.request_last;
    assign o_out.status        = r_result.status;
    assign o_out.header_valid  = r_result.header_valid;
    assign o_out.version_byte  = r_result.version_byte;
    assign o_out.compress_mode = r_result.compress_mode;
    assign o_out.encrypt_mode  = r_result.encrypt_mode;
    assign o_out.method_code   = r_result.method_code;
    assign o_out.package_count = r_result.package_count;

endmodule
